/* design/damt_pkg.sv */
// Shared types and constants of the daily alarm match table.
package damt_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned MinPerDay = 1440;
  localparam int unsigned MinPerHour = 60;
  localparam int unsigned TodW = 11;
  localparam int unsigned RawW = 12;

  typedef enum logic [2:0] {
    OpAdd    = 3'd0,
    OpRemove = 3'd1,
    OpClear  = 3'd2,
    OpToggle = 3'd3,
    OpRead   = 3'd4,
    OpCheck  = 3'd5,
    OpNext   = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] entry_index;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] day_of_month;
    logic [7:0] tray_a;
    logic [7:0] tray_b;
    logic [7:0] tray_c;
    logic [7:0] tray_d;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] out_hour;
    logic [5:0] out_minute;
    logic [7:0] out_tray_a;
    logic [7:0] out_tray_b;
    logic [7:0] out_tray_c;
    logic [7:0] out_tray_d;
    logic       out_enabled;
    logic       out_fired;
    logic [4:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] tray_d;
    logic [7:0] tray_c;
    logic [7:0] tray_b;
    logic [7:0] tray_a;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } mem_wr_t;

  typedef struct packed {
    logic [4:0]      hour;
    logic [5:0]      minute;
    logic [TodW-1:0] base_tod;
    logic [TodW-1:0] best;
    logic [4:0]      cmp_hour;
    logic [5:0]      cmp_minute;
  } dist_req_t;

  typedef struct packed {
    logic [TodW-1:0] fwd;
    logic            less;
    logic            match;
  } dist_rsp_t;

endpackage

/* design/damt_if.sv */
// Valid/ready channel interfaces for request and response beats.
interface damt_in_if import damt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface damt_out_if import damt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/damt_store.sv */
// Entry memory: one write port, one registered read port.
module damt_store import damt_pkg::*; (
  input  logic            clk_i,
  input  mem_wr_t         wr_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output entry_t          rd_data_o
);

  entry_t mem_q [MaxEntries];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

/* design/damt_dist.sv */
// Shared unit: minute of day, forward distance, distance compare and time match.
module damt_dist import damt_pkg::*; (
  input  dist_req_t req_i,
  output dist_rsp_t rsp_o
);

  logic [RawW-1:0] raw;
  logic [RawW-1:0] tod;
  logic [RawW-1:0] diff;
  logic [RawW-1:0] wrapped;

  always_comb begin
    raw = RawW'(req_i.hour) * RawW'(MinPerHour) + RawW'(req_i.minute);
    tod = (raw >= RawW'(MinPerDay)) ? raw - RawW'(MinPerDay) : raw;
    diff = tod - RawW'(req_i.base_tod);
    wrapped = diff + RawW'(MinPerDay);
    rsp_o.fwd = diff[RawW-1] ? wrapped[TodW-1:0] : diff[TodW-1:0];
    rsp_o.less = rsp_o.fwd < req_i.best;
    rsp_o.match = (req_i.hour == req_i.cmp_hour) && (req_i.minute == req_i.cmp_minute);
  end

endmodule

/* design/daily_alarm_match_table.sv */
// Top level of the daily alarm match table: sequencer, flags and result register.
//
//   channel  dir  beat          handshake
//   req_i    in   in_item_t     valid/ready, taken when both high
//   rsp_o    out  out_item_t    valid/ready, taken when both high
//
// Add, clear, toggle and bad requests go from StExec straight to StFinish.
// Read, remove, check and next pass through StScan, one entry per cycle through
// the memory read port and the shared unit; an empty scan reads no entry, and
// a check stops at the first enabled, unfired entry whose time matches.
// Reset empties the table; no clearing pass is needed.
// A result waiting in the output register holds; the next request is still taken.
module daily_alarm_match_table import damt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  damt_in_if.sink  req_i,
  damt_out_if.source rsp_o
);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StScan,
    StFinish
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [4:0]        last_day_q, last_day_d;
  logic [CntW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   end_q, end_d;
  logic              pend_vld_q, pend_vld_d;
  logic              out_vld_q, out_vld_d;

  in_item_t          item_q, item_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [MaxEntries-1:0] en_q, en_d;
  logic [MaxEntries-1:0] fired_q, fired_d;
  logic [TodW-1:0]   now_q, now_d;
  logic [TodW-1:0]   best_q, best_d;
  logic              res_ok_q, res_ok_d;
  entry_t            res_entry_q, res_entry_d;
  logic              res_en_q, res_en_d;
  logic              res_fired_q, res_fired_d;
  out_item_t         out_q, out_d;

  mem_wr_t           mem_wr;
  entry_t            rd_data;
  dist_req_t         dist_req;
  dist_rsp_t         dist_rsp;
  logic              idx_ok;
  logic [IdxW-1:0]   item_idx;
  logic [IdxW-1:0]   used_idx;

  damt_store u_store (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_addr_i (rd_ptr_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  damt_dist u_dist (
    .req_i (dist_req),
    .rsp_o (dist_rsp)
  );

  assign req_i.ready   = (state_q == StIdle);
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    last_day_d  = last_day_q;
    rd_ptr_d    = rd_ptr_q;
    end_d       = end_q;
    pend_vld_d  = 1'b0;
    pend_idx_d  = pend_idx_q;
    out_vld_d   = out_vld_q;
    item_d      = item_q;
    en_d        = en_q;
    fired_d     = fired_q;
    now_d       = now_q;
    best_d      = best_q;
    res_ok_d    = res_ok_q;
    res_entry_d = res_entry_q;
    res_en_d    = res_en_q;
    res_fired_d = res_fired_q;
    out_d       = out_q;

    idx_ok   = 32'(item_q.entry_index) < 32'(used_q);
    item_idx = IdxW'(item_q.entry_index);
    used_idx = used_q[IdxW-1:0];

    mem_wr.we          = 1'b0;
    mem_wr.addr        = used_idx;
    mem_wr.data.hour   = item_q.hour;
    mem_wr.data.minute = item_q.minute;
    mem_wr.data.tray_a = item_q.tray_a;
    mem_wr.data.tray_b = item_q.tray_b;
    mem_wr.data.tray_c = item_q.tray_c;
    mem_wr.data.tray_d = item_q.tray_d;

    dist_req.hour       = rd_data.hour;
    dist_req.minute     = rd_data.minute;
    dist_req.base_tod   = now_q;
    dist_req.best       = best_q;
    dist_req.cmp_hour   = item_q.hour;
    dist_req.cmp_minute = item_q.minute;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          item_d  = req_i.payload;
          state_d = StExec;
        end
      end

      StExec: begin
        res_ok_d    = 1'b0;
        res_entry_d = '0;
        res_en_d    = 1'b0;
        res_fired_d = 1'b0;
        state_d     = StFinish;
        case (op_e'(item_q.opcode))
          OpAdd: begin
            if (32'(used_q) < MaxEntries) begin
              mem_wr.we          = 1'b1;
              en_d[used_idx]     = 1'b1;
              fired_d[used_idx]  = 1'b0;
              used_d             = used_q + 1'b1;
              res_ok_d           = 1'b1;
            end
          end
          OpRemove: begin
            if (idx_ok) begin
              for (int j = 0; j < MaxEntries - 1; j++) begin
                if (32'(j) >= 32'(item_q.entry_index)) begin
                  en_d[j]    = en_q[j+1];
                  fired_d[j] = fired_q[j+1];
                end
              end
              used_d   = used_q - 1'b1;
              res_ok_d = 1'b1;
              rd_ptr_d = CntW'(32'(item_q.entry_index) + 1);
              end_d    = used_q;
              state_d  = StScan;
            end
          end
          OpClear: begin
            used_d   = '0;
            res_ok_d = 1'b1;
          end
          OpToggle: begin
            if (idx_ok) begin
              en_d[item_idx] = ~en_q[item_idx];
              res_ok_d       = 1'b1;
            end
          end
          OpRead: begin
            if (idx_ok) begin
              rd_ptr_d = CntW'(item_q.entry_index);
              end_d    = CntW'(32'(item_q.entry_index) + 1);
              state_d  = StScan;
            end
          end
          OpCheck: begin
            if (item_q.day_of_month != last_day_q) begin
              last_day_d = item_q.day_of_month;
              fired_d    = '0;
            end
            rd_ptr_d = '0;
            end_d    = used_q;
            state_d  = StScan;
          end
          OpNext: begin
            dist_req.hour     = item_q.hour;
            dist_req.minute   = item_q.minute;
            dist_req.base_tod = '0;
            now_d             = dist_rsp.fwd;
            best_d            = TodW'(MinPerDay);
            rd_ptr_d          = '0;
            end_d             = used_q;
            state_d           = StScan;
          end
          default: begin
          end
        endcase
      end

      StScan: begin
        if (rd_ptr_q < end_q) begin
          rd_ptr_d   = rd_ptr_q + 1'b1;
          pend_vld_d = 1'b1;
          pend_idx_d = rd_ptr_q[IdxW-1:0];
        end else if (!pend_vld_q) begin
          state_d = StFinish;
        end
        if (pend_vld_q) begin
          case (op_e'(item_q.opcode))
            OpRemove: begin
              mem_wr.we   = 1'b1;
              mem_wr.addr = pend_idx_q - 1'b1;
              mem_wr.data = rd_data;
            end
            OpRead: begin
              res_ok_d    = 1'b1;
              res_entry_d = rd_data;
              res_en_d    = en_q[pend_idx_q];
              res_fired_d = fired_q[pend_idx_q];
            end
            OpCheck: begin
              if (en_q[pend_idx_q] && !fired_q[pend_idx_q] && dist_rsp.match) begin
                fired_d[pend_idx_q] = 1'b1;
                res_ok_d            = 1'b1;
                res_entry_d         = rd_data;
                res_en_d            = 1'b1;
                res_fired_d         = 1'b1;
                pend_vld_d          = 1'b0;
                state_d             = StFinish;
              end
            end
            OpNext: begin
              if (en_q[pend_idx_q] && dist_rsp.less) begin
                best_d      = dist_rsp.fwd;
                res_ok_d    = 1'b1;
                res_entry_d = rd_data;
                res_en_d    = 1'b1;
                res_fired_d = fired_q[pend_idx_q];
              end
            end
            default: begin
            end
          endcase
        end
      end

      StFinish: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d.ok          = res_ok_q;
          out_d.out_hour    = res_entry_q.hour;
          out_d.out_minute  = res_entry_q.minute;
          out_d.out_tray_a  = res_entry_q.tray_a;
          out_d.out_tray_b  = res_entry_q.tray_b;
          out_d.out_tray_c  = res_entry_q.tray_c;
          out_d.out_tray_d  = res_entry_q.tray_d;
          out_d.out_enabled = res_en_q;
          out_d.out_fired   = res_fired_q;
          out_d.entry_count = 5'(used_q);
          out_vld_d         = 1'b1;
          state_d           = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      used_q     <= '0;
      last_day_q <= '0;
      rd_ptr_q   <= '0;
      end_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      last_day_q <= last_day_d;
      rd_ptr_q   <= rd_ptr_d;
      end_q      <= end_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    pend_idx_q  <= pend_idx_d;
    en_q        <= en_d;
    fired_q     <= fired_d;
    now_q       <= now_d;
    best_q      <= best_d;
    res_ok_q    <= res_ok_d;
    res_entry_q <= res_entry_d;
    res_en_q    <= res_en_d;
    res_fired_q <= res_fired_d;
    out_q       <= out_d;
  end

endmodule
